/* hw/rtl/cpc_pkg.sv */
// shared types, widths and the arctangent table for the cartesian/polar converter
package cpc_pkg;

    // field widths
    localparam int COORD_WIDTH = 16;
    localparam int ANGLE_BITS  = 16;
    localparam int ITERATIONS  = 16;

    // internal fixed-point formats
    localparam int GUARD     = 36 - COORD_WIDTH;
    localparam int XW        = COORD_WIDTH + GUARD + 4;
    localparam int ZW        = 35;
    localparam int KINV      = 10188014;
    localparam int KINV_BITS = 24;
    localparam int PW        = XW + KINV_BITS + 1;
    localparam int SH        = GUARD + KINV_BITS;
    localparam int RW        = PW - SH;

    // cycles from an accepted word to its result strobe
    localparam int LATENCY = ITERATIONS + 3;

    // arctangent of 2^-i in units of 2^-32 turn
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // conversion kinds
    localparam logic KIND_TO_POLAR = 1'b0;
    localparam logic KIND_TO_RECT  = 1'b1;

    // input word
    typedef struct packed {
        logic                           kind;
        logic signed [COORD_WIDTH-1:0]  coord_a;
        logic signed [COORD_WIDTH-1:0]  coord_b;
    } cpc_in_t;

    // result word
    typedef struct packed {
        logic        [COORD_WIDTH-1:0]  magnitude;
        logic signed [ANGLE_BITS-1:0]   angle;
        logic signed [COORD_WIDTH-1:0]  x_out;
        logic signed [COORD_WIDTH-1:0]  y_out;
    } cpc_out_t;

    // cordic working set carried down the pipeline
    typedef struct packed {
        logic                  kind;
        logic                  org;
        logic signed [XW-1:0]  x;
        logic signed [XW-1:0]  y;
        logic signed [ZW-1:0]  z;
    } cpc_work_t;

    // table entry widened to the angle accumulator
    function automatic logic signed [ZW-1:0] atan_of(input logic [4:0] idx);
        return signed'(ZW'(ATAN_TAB[idx]));
    endfunction

endpackage

/* hw/rtl/cpc_prerot.sv */
// input stage: quadrant folding and fixed-point scaling ahead of the cordic pipeline
module cpc_prerot (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  cpc_pkg::cpc_in_t cmd,
    output logic             out_valid,
    output cpc_pkg::cpc_work_t work
);
    import cpc_pkg::*;

    localparam logic signed [ZW-1:0] Z_HALF    = ZW'(64'h8000_0000);
    localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(64'h4000_0000);

    logic signed [COORD_WIDTH-1:0] a_s;
    logic signed [COORD_WIDTH-1:0] b_s;
    logic signed [ANGLE_BITS-1:0]  ang_s;
    logic signed [XW-1:0]          a_ext;
    logic signed [XW-1:0]          b_ext;
    logic signed [ZW-1:0]          z_in;
    cpc_work_t                     work_next;
    cpc_work_t                     work_reg;
    logic                          valid_reg;

    // fold the operands into the right half plane / the cordic range
    always_comb
    begin
        a_s   = cmd.coord_a;
        b_s   = cmd.coord_b;
        ang_s = cmd.coord_b[ANGLE_BITS-1:0];
        a_ext = XW'(a_s) <<< GUARD;
        b_ext = XW'(b_s) <<< GUARD;
        z_in  = ZW'(ang_s) <<< (32 - ANGLE_BITS);

        work_next.kind = cmd.kind;
        work_next.org  = 1'b0;
        work_next.x    = a_ext;
        work_next.y    = b_ext;
        work_next.z    = '0;

        if (cmd.kind == KIND_TO_POLAR)
        begin
            work_next.org = (a_s == '0) && (b_s == '0);
            if (a_s < 0)
            begin
                work_next.x = -a_ext;
                work_next.y = -b_ext;
                work_next.z = Z_HALF;
            end
        end
        else
        begin
            work_next.y = '0;
            work_next.z = z_in;
            if (z_in > Z_QUARTER)
            begin
                work_next.z = z_in - Z_HALF;
                work_next.x = -a_ext;
            end
            else if (z_in < -Z_QUARTER)
            begin
                work_next.z = z_in + Z_HALF;
                work_next.x = -a_ext;
            end
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid)
            work_reg <= work_next;
    end

    assign out_valid = valid_reg;
    assign work      = work_reg;

endmodule

/* hw/rtl/cpc_core.sv */
// unrolled cordic pipeline, one registered micro-rotation per stage
module cpc_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  cpc_pkg::cpc_work_t in_work,
    output logic               out_valid,
    output cpc_pkg::cpc_work_t out_work
);
    import cpc_pkg::*;

    logic      valid_reg [ITERATIONS+1];
    cpc_work_t work_reg  [ITERATIONS+1];

    // stage zero is the incoming word
    always_comb
    begin
        valid_reg[0] = in_valid;
        work_reg[0]  = in_work;
    end

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_stage
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [ZW-1:0] zs;
        logic signed [ZW-1:0] da;
        logic                 ccw;
        cpc_work_t            work_next;

        // one micro-rotation, direction from y sign or residual angle sign
        always_comb
        begin
            xs  = work_reg[i].x;
            ys  = work_reg[i].y;
            zs  = work_reg[i].z;
            da  = atan_of(5'(i));
            ccw = (work_reg[i].kind == KIND_TO_POLAR) ? (ys < 0) : (zs >= 0);
            work_next = work_reg[i];
            if (ccw)
            begin
                work_next.x = xs - (ys >>> i);
                work_next.y = ys + (xs >>> i);
                work_next.z = zs - da;
            end
            else
            begin
                work_next.x = xs + (ys >>> i);
                work_next.y = ys - (xs >>> i);
                work_next.z = zs + da;
            end
        end

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else
                valid_reg[i+1] <= valid_reg[i];
        end

        // payload
        always_ff @(posedge clk)
        begin
            if (valid_reg[i])
                work_reg[i+1] <= work_next;
        end
    end

    assign out_valid = valid_reg[ITERATIONS];
    assign out_work  = work_reg[ITERATIONS];

endmodule

/* hw/rtl/cpc_post.sv */
// gain correction multiply, rounding and saturation to the result word
module cpc_post (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  cpc_pkg::cpc_work_t in_work,
    output logic               out_valid,
    output cpc_pkg::cpc_out_t  out_word
);
    import cpc_pkg::*;

    localparam logic signed [KINV_BITS:0] KINV_S    = (KINV_BITS+1)'(KINV);
    localparam logic signed [PW-1:0]      P_RND     = PW'(1) <<< (SH - 1);
    localparam logic signed [ZW-1:0]      Z_RND     = ZW'(1) <<< (31 - ANGLE_BITS);
    localparam logic signed [RW-1:0]      MAG_MAX   = (RW'(1) <<< COORD_WIDTH) - RW'(1);
    localparam logic signed [RW-1:0]      COORD_MAX = (RW'(1) <<< (COORD_WIDTH-1)) - RW'(1);
    localparam logic signed [RW-1:0]      COORD_MIN = -(RW'(1) <<< (COORD_WIDTH-1));

    logic                           valid_a_reg;
    logic                           kind_a_reg;
    logic                           org_a_reg;
    logic signed [PW-1:0]           px_reg;
    logic signed [PW-1:0]           py_reg;
    logic signed [ANGLE_BITS-1:0]   ang_reg;
    logic signed [PW-1:0]           px_next;
    logic signed [PW-1:0]           py_next;
    logic signed [ZW-1:0]           z_rnd;
    logic signed [PW-1:0]           px_rnd;
    logic signed [PW-1:0]           py_rnd;
    logic signed [RW-1:0]           rx;
    logic signed [RW-1:0]           ry;
    logic                           valid_b_reg;
    cpc_out_t                       word_next;
    cpc_out_t                       word_reg;

    // multiply by the inverse cordic gain, round the angle
    always_comb
    begin
        px_next = in_work.x * KINV_S;
        py_next = in_work.y * KINV_S;
        z_rnd   = (in_work.z + Z_RND) >>> (32 - ANGLE_BITS);
    end

    // round half up, clip, zero the fields of the other conversion
    always_comb
    begin
        px_rnd = (px_reg + P_RND) >>> SH;
        py_rnd = (py_reg + P_RND) >>> SH;
        rx     = px_rnd[RW-1:0];
        ry     = py_rnd[RW-1:0];
        word_next = '0;
        if (kind_a_reg == KIND_TO_POLAR)
        begin
            if (!org_a_reg)
            begin
                word_next.angle = ang_reg;
                if (rx < 0)
                    word_next.magnitude = '0;
                else if (rx > MAG_MAX)
                    word_next.magnitude = MAG_MAX[COORD_WIDTH-1:0];
                else
                    word_next.magnitude = rx[COORD_WIDTH-1:0];
            end
        end
        else
        begin
            if (rx > COORD_MAX)
                word_next.x_out = COORD_MAX[COORD_WIDTH-1:0];
            else if (rx < COORD_MIN)
                word_next.x_out = COORD_MIN[COORD_WIDTH-1:0];
            else
                word_next.x_out = rx[COORD_WIDTH-1:0];
            if (ry > COORD_MAX)
                word_next.y_out = COORD_MAX[COORD_WIDTH-1:0];
            else if (ry < COORD_MIN)
                word_next.y_out = COORD_MIN[COORD_WIDTH-1:0];
            else
                word_next.y_out = ry[COORD_WIDTH-1:0];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    // product stage payload
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            kind_a_reg <= in_work.kind;
            org_a_reg  <= in_work.org;
            px_reg     <= px_next;
            py_reg     <= py_next;
            ang_reg    <= z_rnd[ANGLE_BITS-1:0];
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (valid_a_reg)
            word_reg <= word_next;
    end

    assign out_valid = valid_b_reg;
    assign out_word  = word_reg;

endmodule

/* hw/rtl/cartesian_polar_conversion.sv */
// top level: cartesian/polar conversion on a pipelined cordic
// a taken word passes the prerot register, every cordic stage register and the post product and output registers
// throughput: one word per cycle; the unrolled cordic stages set the depth, busy stays low
// each result is held for one cycle under done; the receiver cannot stall the pipeline
// reset clears every valid bit at once; payload registers are not reset
module cartesian_polar_conversion (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cpc_pkg::cpc_in_t  cmd,
    output logic              done,
    output cpc_pkg::cpc_out_t result
);
    import cpc_pkg::*;

    logic      take;
    logic      pre_valid;
    cpc_work_t pre_work;
    logic      core_valid;
    cpc_work_t core_work;

    // a new word enters every cycle
    assign busy = 1'b0;
    assign take = start && !busy;

    // quadrant folding
    cpc_prerot u_prerot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (take),
        .cmd       (cmd),
        .out_valid (pre_valid),
        .work      (pre_work)
    );

    // cordic iterations
    cpc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pre_valid),
        .in_work   (pre_work),
        .out_valid (core_valid),
        .out_work  (core_work)
    );

    // gain correction and output
    cpc_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (core_valid),
        .in_work   (core_work),
        .out_valid (done),
        .out_word  (result)
    );

    // every result comes from a word taken earlier, at the depth of the pipeline
    a_done_from_take: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(take, LATENCY))
        else $error("result strobe without a matching input word");

    // every taken word gives its result on time
    a_take_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> ##LATENCY done)
        else $error("input word lost in the pipeline");

    // only one conversion's fields carry data
    a_fields_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.magnitude == '0 && result.angle == '0) ||
                  (result.x_out == '0 && result.y_out == '0)))
        else $error("polar and cartesian fields both nonzero");

endmodule

/* verif/cartesian_polar_conversion_tb.sv */
// testbench for the cartesian/polar converter: directed corners, random words, cordic predictor
`timescale 1ns / 1ps

module cartesian_polar_conversion_tb;
    import cpc_pkg::*;

    // fixed-point formats of the predictor
    localparam int     FRAC_BITS     = 20;
    localparam int     CORDIC_STEPS  = 16;
    localparam longint INV_GAIN      = 64'sd10188014;
    localparam int     INV_GAIN_BITS = 24;
    localparam longint HALF_TURN     = 64'sd1 <<< 31;
    localparam longint QUARTER_TURN  = 64'sd1 <<< 30;
    localparam longint COORD_MIN     = -(64'sd1 <<< 15);
    localparam longint COORD_MAX     = (64'sd1 <<< 15) - 1;
    localparam longint MAG_MAX       = (64'sd1 <<< 16) - 1;

    // pipeline depth of the block and the stall allowance of the watchdog
    localparam int PIPE_DEPTH  = 19;
    localparam int STALL_LIMIT = 500;

    // arctangent of 2^-i in 2^-32 turn
    localparam longint ARCTAN_TURNS [CORDIC_STEPS] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    // coordinate corners, including the quarter-turn angles
    localparam logic signed [15:0] CORNER_VALUES [8] = '{
        16'h8000, 16'h8001, 16'hFFFF, 16'h0000,
        16'h0001, 16'h7FFF, 16'h4000, 16'hC000
    };

    logic     clk;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    cpc_in_t  cmd   = '0;
    logic     done;
    cpc_out_t result;

    cpc_out_t pending_conversions [$];
    int       mismatches   = 0;
    int       stall_cycles = 0;

    cartesian_polar_conversion u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // strip the cordic gain and round half up
    function automatic longint remove_gain(input longint v);
        longint p;
        p = v * INV_GAIN + (64'sd1 <<< (FRAC_BITS + INV_GAIN_BITS - 1));
        return p >>> (FRAC_BITS + INV_GAIN_BITS);
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // expected result of one conversion word
    function automatic cpc_out_t predict_conversion(input cpc_in_t w);
        longint   a;
        longint   b;
        longint   x;
        longint   y;
        longint   z;
        longint   nx;
        longint   ny;
        longint   ang;
        cpc_out_t r;
        r = '0;
        a = w.coord_a;
        b = w.coord_b;
        if (w.kind == KIND_TO_POLAR)
        begin
            // origin gives all zeros
            if (a == 0 && b == 0)
                return r;
            x = a <<< FRAC_BITS;
            y = b <<< FRAC_BITS;
            z = 0;
            // left half plane: turn by half a turn first
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = HALF_TURN;
            end
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                if (y < 0)
                begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z  = z - ARCTAN_TURNS[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z  = z + ARCTAN_TURNS[i];
                end
                x = nx;
                y = ny;
            end
            r.magnitude = 16'(clip(remove_gain(x), 0, MAG_MAX));
            ang = (z + (64'sd1 <<< 15)) >>> 16;
            r.angle = ang[15:0];
        end
        else
        begin
            x = a <<< FRAC_BITS;
            y = 0;
            z = b <<< 16;
            // fold the angle into the right half plane
            if (z > QUARTER_TURN)
            begin
                z = z - HALF_TURN;
                x = -x;
            end
            else if (z < -QUARTER_TURN)
            begin
                z = z + HALF_TURN;
                x = -x;
            end
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z  = z - ARCTAN_TURNS[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z  = z + ARCTAN_TURNS[i];
                end
                x = nx;
                y = ny;
            end
            r.x_out = 16'(clip(remove_gain(x), COORD_MIN, COORD_MAX));
            r.y_out = 16'(clip(remove_gain(y), COORD_MIN, COORD_MAX));
        end
        return r;
    endfunction

    task automatic check_field(input string label, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("[%0t] %s mismatch: expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    // result checker, word predictor and watchdog
    always @(posedge clk)
    begin
        cpc_out_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_conversions.size() == 0)
                begin
                    mismatches++;
                    $display("[%0t] unexpected result word: actual %h", $time, result);
                end
                else
                begin
                    want = pending_conversions.pop_front();
                    check_field("magnitude", want.magnitude, result.magnitude);
                    check_field("angle", want.angle, result.angle);
                    check_field("x_out", want.x_out, result.x_out);
                    check_field("y_out", want.y_out, result.y_out);
                end
            end
            if (start && !busy)
                pending_conversions.push_back(predict_conversion(cmd));
            if (done || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] watchdog: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // present one word and hold it until taken; start stays high afterwards
    task automatic issue_conversion(input logic kind, input logic signed [15:0] a,
                                    input logic signed [15:0] b);
        start        <= 1'b1;
        cmd.kind     <= kind;
        cmd.coord_a  <= a;
        cmd.coord_b  <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // sender gap with noise on the command bus
    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles)
        begin
            cmd <= {1'($urandom), 16'($urandom), 16'($urandom)};
            @(posedge clk);
        end
    endtask

    // wait for the checker to queue the word taken at the last edge before polling the queue
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_conversions.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return CORNER_VALUES[$urandom_range(0, 7)];
            1: return 16'($urandom_range(0, 128) - 64);
            default: return 16'($urandom);
        endcase
    endfunction

    // corners of the vectoring path: origin, axes, left half plane, largest magnitude
    task automatic test_directed_to_polar();
        issue_conversion(KIND_TO_POLAR, 16'sd0, 16'sd0);
        issue_conversion(KIND_TO_POLAR, 16'sd32767, 16'sd0);
        issue_conversion(KIND_TO_POLAR, -16'sd32768, 16'sd0);
        issue_conversion(KIND_TO_POLAR, -16'sd1, 16'sd0);
        issue_conversion(KIND_TO_POLAR, 16'sd0, 16'sd32767);
        issue_conversion(KIND_TO_POLAR, 16'sd0, -16'sd32768);
        issue_conversion(KIND_TO_POLAR, 16'sd32767, 16'sd32767);
        issue_conversion(KIND_TO_POLAR, -16'sd32768, -16'sd32768);
        issue_conversion(KIND_TO_POLAR, -16'sd32768, 16'sd32767);
        issue_conversion(KIND_TO_POLAR, 16'sd1, -16'sd1);
        issue_conversion(KIND_TO_POLAR, -16'sd1, 16'sd1);
    endtask

    // corners of the rotation path: quarter turns, wrap, negative radius, saturation
    task automatic test_directed_to_rect();
        issue_conversion(KIND_TO_RECT, 16'sd32767, 16'sd0);
        issue_conversion(KIND_TO_RECT, 16'sd32767, 16'sd16384);
        issue_conversion(KIND_TO_RECT, 16'sd32767, -16'sd16384);
        issue_conversion(KIND_TO_RECT, 16'sd32767, 16'sd16385);
        issue_conversion(KIND_TO_RECT, 16'sd32767, -16'sd16385);
        issue_conversion(KIND_TO_RECT, 16'sd32767, -16'sd32768);
        issue_conversion(KIND_TO_RECT, 16'sd32767, 16'sd32767);
        issue_conversion(KIND_TO_RECT, -16'sd32768, 16'sd0);
        issue_conversion(KIND_TO_RECT, -16'sd32768, 16'sd8192);
        issue_conversion(KIND_TO_RECT, 16'sd0, 16'sd12345);
        issue_conversion(KIND_TO_RECT, 16'sd1, -16'sd1);
        issue_conversion(KIND_TO_RECT, 16'sd23170, 16'sd8192);
    endtask

    // random words with bursts of sender gaps, gap rate changing every stretch
    task automatic test_random_with_gaps(input int count);
        int gap_odds;
        gap_odds = 0;
        for (int n = 0; n < count; n++)
        begin
            if (n % 48 == 0)
                gap_odds = $urandom_range(0, 3);
            issue_conversion(1'($urandom_range(0, 1)), pick_coord(), pick_coord());
            if (gap_odds != 0 && $urandom_range(1, 4) <= gap_odds)
                pause_sender($urandom_range(1, 11));
        end
    endtask

    // sender holds off until the pipeline is empty, then resumes
    task automatic test_sender_pause();
        wait_for_results();
        issue_conversion(KIND_TO_POLAR, pick_coord(), pick_coord());
        issue_conversion(KIND_TO_RECT, pick_coord(), pick_coord());
    endtask

    // closing stretch: back to back words, no gaps
    task automatic test_back_to_back(input int count);
        for (int n = 0; n < count; n++)
            issue_conversion(1'($urandom_range(0, 1)), pick_coord(), pick_coord());
    endtask

    // test sequence
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_to_polar();
        test_directed_to_rect();
        test_random_with_gaps(350);
        test_sender_pause();
        test_random_with_gaps(350);
        test_back_to_back(330);
        wait_for_results();
        repeat (PIPE_DEPTH + 4) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/cpc_pkg.sv
hw/rtl/cpc_prerot.sv
hw/rtl/cpc_core.sv
hw/rtl/cpc_post.sv
hw/rtl/cartesian_polar_conversion.sv
verif/cartesian_polar_conversion_tb.sv
